>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. Each expects clk in scope; CCC_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define CCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define CCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/ccc_pkg.sv
package ccc_pkg;

  localparam int CMD_W      = 3;
  localparam int TIME_W     = 32;
  localparam int MV_W       = 13;
  localparam int PACK_MV_W  = 21;
  localparam int CA_W       = 23;
  localparam int CUR_W      = 24;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic signed [CUR_W-1:0] LOW_CURRENT_CA = 24'sd100;
  localparam logic [TIME_W-1:0]       DONE_HOLD_MS   = 32'd60000;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE    = 3'd0,
    CMD_CHARGE  = 3'd1,
    CMD_DRAIN   = 3'd2,
    CMD_IDLE    = 3'd3,
    CMD_BALANCE = 3'd4
  } cmd_t;

  typedef enum logic [4:0] {
    MODE_OFF  = 5'b00001,
    MODE_INIT = 5'b00010,
    MODE_CC   = 5'b00100,
    MODE_CV   = 5'b01000,
    MODE_DONE = 5'b10000
  } mode_t;

  localparam logic [MODE_W-1:0] MODE_CODE_OFF  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_INIT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_CC   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_CV   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_DONE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PACK_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CC_PACK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_CUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAL_ON      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAL_OFF     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BAL_IDLE    = 3'd6;

  typedef struct packed {
    logic [MV_W-1:0]      cell_limit_mv;
    logic [PACK_MV_W-1:0] pack_limit_mv;
    logic [PACK_MV_W-1:0] cc_pack_mv;
    logic [CA_W-1:0]      charge_current_ca;
    logic [MV_W-1:0]      balance_on_delta_mv;
    logic [MV_W-1:0]      balance_off_delta_mv;
    logic [MV_W-1:0]      balance_idle_mv;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [TIME_W-1:0]        now_ms;
    logic                     contactors_are_closed;
    logic                     charger_fault;
    logic [MV_W-1:0]          max_cell_mv;
    logic [MV_W-1:0]          min_cell_mv;
    logic signed [CUR_W-1:0]  pack_current_ca;
  } in_word_t;

  typedef struct packed {
    logic                 error_code;
    logic                 contactor_close;
    logic                 charger_enable;
    logic                 charger_clear_latch;
    logic [PACK_MV_W-1:0] charger_target_mv;
    logic [CA_W-1:0]      charger_target_ca;
    logic                 balance_on;
    logic [MV_W-1:0]      balance_target_mv;
    logic [MODE_W-1:0]    charge_mode;
  } out_word_t;

  typedef struct packed {
    mode_t                mode;
    logic                 balancing;
    logic [TIME_W-1:0]    last_high_ms;
    logic                 contactor_close;
    logic                 charger_enable;
    logic [PACK_MV_W-1:0] charger_mv;
    logic [CA_W-1:0]      charger_ca;
    logic                 balance_on;
    logic [MV_W-1:0]      balance_mv;
  } state_t;

  function automatic logic [MODE_W-1:0] mode_code(mode_t m);
    logic [MODE_W-1:0] c;
    unique case (m)
      MODE_OFF:  c = MODE_CODE_OFF;
      MODE_INIT: c = MODE_CODE_INIT;
      MODE_CC:   c = MODE_CODE_CC;
      MODE_CV:   c = MODE_CODE_CV;
      MODE_DONE: c = MODE_CODE_DONE;
      default:   c = MODE_CODE_OFF;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/ccc_in_if.sv
interface ccc_in_if;
  import ccc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [TIME_W-1:0]       now_ms;
  logic                    contactors_are_closed;
  logic                    charger_fault;
  logic [MV_W-1:0]         max_cell_mv;
  logic [MV_W-1:0]         min_cell_mv;
  logic signed [CUR_W-1:0] pack_current_ca;

  modport source (
    output valid, cmd, now_ms, contactors_are_closed, charger_fault,
           max_cell_mv, min_cell_mv, pack_current_ca,
    input  ready
  );

  modport sink (
    input  valid, cmd, now_ms, contactors_are_closed, charger_fault,
           max_cell_mv, min_cell_mv, pack_current_ca,
    output ready
  );
endinterface

>>> rtl/core/ccc_out_if.sv
interface ccc_out_if;
  import ccc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 error_code;
  logic                 contactor_close;
  logic                 charger_enable;
  logic                 charger_clear_latch;
  logic [PACK_MV_W-1:0] charger_target_mv;
  logic [CA_W-1:0]      charger_target_ca;
  logic                 balance_on;
  logic [MV_W-1:0]      balance_target_mv;
  logic [MODE_W-1:0]    charge_mode;

  modport source (
    output valid, error_code, contactor_close, charger_enable, charger_clear_latch,
           charger_target_mv, charger_target_ca, balance_on, balance_target_mv,
           charge_mode,
    input  ready
  );

  modport sink (
    input  valid, error_code, contactor_close, charger_enable, charger_clear_latch,
           charger_target_mv, charger_target_ca, balance_on, balance_target_mv,
           charge_mode,
    output ready
  );
endinterface

>>> rtl/core/ccc_cfg_regs.sv
module ccc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ccc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccc_pkg::CFG_DATA_W-1:0] cfg_data,
  output ccc_pkg::cfg_t                  cfg
);
  import ccc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      // indexes beyond the list are dropped
      unique case (cfg_index)
        CFG_CELL_LIMIT: cfg_nxt.cell_limit_mv        = cfg_data[MV_W-1:0];
        CFG_PACK_LIMIT: cfg_nxt.pack_limit_mv        = cfg_data[PACK_MV_W-1:0];
        CFG_CC_PACK:    cfg_nxt.cc_pack_mv           = cfg_data[PACK_MV_W-1:0];
        CFG_CHARGE_CUR: cfg_nxt.charge_current_ca    = cfg_data[CA_W-1:0];
        CFG_BAL_ON:     cfg_nxt.balance_on_delta_mv  = cfg_data[MV_W-1:0];
        CFG_BAL_OFF:    cfg_nxt.balance_off_delta_mv = cfg_data[MV_W-1:0];
        CFG_BAL_IDLE:   cfg_nxt.balance_idle_mv      = cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cell_limit_mv        <= 13'd3600;
      cfg_r.pack_limit_mv        <= '0;
      cfg_r.cc_pack_mv           <= '0;
      cfg_r.charge_current_ca    <= '0;
      cfg_r.balance_on_delta_mv  <= 13'd50;
      cfg_r.balance_off_delta_mv <= 13'd10;
      cfg_r.balance_idle_mv      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

>>> rtl/core/ccc_step.sv
module ccc_step (
  input  ccc_pkg::cfg_t      cfg,
  input  ccc_pkg::state_t    st,
  input  ccc_pkg::in_word_t  in_word,
  output ccc_pkg::state_t    st_nxt,
  output ccc_pkg::out_word_t out_word
);
  import ccc_pkg::*;

  mode_t                   mode_cmd;
  logic                    stop_req;
  logic [TIME_W-1:0]       last_eff;
  logic [TIME_W-1:0]       elapsed;
  logic                    below_limit;
  logic                    low_current;
  logic signed [MV_W:0]    cell_delta;
  logic                    bal_flag;
  logic                    run_charge;
  logic                    err;
  logic                    clear_latch;
  state_t                  s;

  // request handling ahead of the mode logic
  always_comb begin
    mode_cmd = st.mode;
    stop_req = 1'b0;
    case (in_word.cmd) inside
      CMD_CHARGE: begin
        if (st.mode == MODE_OFF) mode_cmd = MODE_INIT;
      end
      CMD_DRAIN, CMD_IDLE, CMD_BALANCE: begin
        mode_cmd = MODE_OFF;
        stop_req = 1'b1;
      end
      default: ;
    endcase
  end

  // init restarts the low-current timer before the charge check
  assign last_eff    = (mode_cmd == MODE_INIT) ? in_word.now_ms : st.last_high_ms;
  assign elapsed     = in_word.now_ms - last_eff;
  assign below_limit = in_word.max_cell_mv < cfg.cell_limit_mv;
  assign low_current = in_word.pack_current_ca < LOW_CURRENT_CA;
  assign cell_delta  = $signed({1'b0, in_word.max_cell_mv}) -
                       $signed({1'b0, in_word.min_cell_mv});

  // balancing hysteresis
  always_comb begin
    bal_flag = st.balancing;
    if (!st.balancing && (cell_delta > $signed({1'b0, cfg.balance_on_delta_mv}))) begin
      bal_flag = 1'b1;
    end else if (st.balancing &&
                 (cell_delta < $signed({1'b0, cfg.balance_off_delta_mv}))) begin
      bal_flag = 1'b0;
    end
  end

  always_comb begin
    s           = st;
    s.mode      = mode_cmd;
    err         = 1'b0;
    clear_latch = 1'b0;
    run_charge  = 1'b0;
    if (stop_req) s.contactor_close = 1'b0;

    unique case (mode_cmd) inside
      MODE_OFF: begin
        s.balance_on      = 1'b0;
        s.charger_enable  = 1'b0;
        s.contactor_close = 1'b0;
      end
      MODE_INIT: begin
        s.balance_on     = 1'b0;
        s.charger_mv     = '0;
        s.charger_ca     = '0;
        s.charger_enable = 1'b1;
        s.last_high_ms   = in_word.now_ms;
        if (!in_word.contactors_are_closed) begin
          s.contactor_close = 1'b1;
        end else if (in_word.charger_fault) begin
          clear_latch = 1'b1;
        end else begin
          run_charge = 1'b1;
        end
      end
      MODE_CC, MODE_CV: begin
        if (in_word.charger_fault) begin
          s.charger_enable  = 1'b0;
          s.balance_on      = 1'b0;
          s.contactor_close = 1'b0;
          s.mode            = MODE_OFF;
          err               = 1'b1;
        end else begin
          run_charge = 1'b1;
        end
      end
      MODE_DONE: begin
        s.contactor_close = 1'b0;
      end
      default: ;
    endcase

    // settle CC against CV on the cell limit, then charge in that mode, or go to done from CV once current has held low
    if (run_charge) begin
      s.mode           = below_limit ? MODE_CC : MODE_CV;
      s.charger_mv     = below_limit ? cfg.cc_pack_mv : cfg.pack_limit_mv;
      s.charger_ca     = cfg.charge_current_ca;
      s.charger_enable = 1'b1;
      if (!below_limit && low_current && (elapsed >= DONE_HOLD_MS)) begin
        s.charger_enable = 1'b0;
        s.balance_on     = 1'b0;
        s.mode           = MODE_DONE;
        s.balancing      = 1'b0;
      end else begin
        if (!below_limit && !low_current) s.last_high_ms = in_word.now_ms;
        s.balancing  = bal_flag;
        s.balance_on = bal_flag;
        s.balance_mv = bal_flag ? in_word.min_cell_mv : cfg.balance_idle_mv;
      end
    end
  end

  assign st_nxt = s;

  always_comb begin
    out_word.error_code          = err;
    out_word.contactor_close     = s.contactor_close;
    out_word.charger_enable      = s.charger_enable;
    out_word.charger_clear_latch = clear_latch;
    out_word.charger_target_mv   = s.charger_mv;
    out_word.charger_target_ca   = s.charger_ca;
    out_word.balance_on          = s.balance_on;
    out_word.balance_target_mv   = s.balance_mv;
    out_word.charge_mode         = mode_code(s.mode);
  end
endmodule

>>> rtl/core/cc_cv_charge_controller.sv
// CC/CV charge sequencer.
// in_ch carries one control tick per word: a request (none, charge, drain,
// idle, balance), the millisecond count and the pack measurements. out_ch
// returns one result word per tick: contactor, charger and balancing
// requests, the fault pulse bits and the mode after the tick.
// The cfg_ port writes thresholds and setpoints by index; write it only
// while no tick is in flight. There is no read-back.
// A tick taken at one edge is registered, evaluated against the mode state
// and lands in the result register once that register is empty or being
// read; its result is then offered on out_ch. One tick is taken per cycle
// while out_ch keeps taking results: the mode update is a single pass of
// compare-and-select logic between the input and result registers.
// When out_ch stalls the result register holds and the input register takes
// one more word; in_ch.ready drops only when both are full.
// Synchronous reset puts the mode in off, clears all held outputs and timers
// and loads the register reset values; both channels come up empty.
module cc_cv_charge_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  ccc_in_if.sink                         in_ch,
  ccc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [ccc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ccc_pkg::*;
  `include "assert_macros.svh"

  cfg_t      cfg;
  logic      in_valid_r;
  in_word_t  in_word_r;
  state_t    st_r;
  state_t    st_nxt;
  out_word_t res_word;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      advance;

  ccc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ccc_step u_step (
    .cfg      (cfg),
    .st       (st_r),
    .in_word  (in_word_r),
    .st_nxt   (st_nxt),
    .out_word (res_word)
  );

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_word_r.cmd                   <= in_ch.cmd;
      in_word_r.now_ms                <= in_ch.now_ms;
      in_word_r.contactors_are_closed <= in_ch.contactors_are_closed;
      in_word_r.charger_fault         <= in_ch.charger_fault;
      in_word_r.max_cell_mv           <= in_ch.max_cell_mv;
      in_word_r.min_cell_mv           <= in_ch.min_cell_mv;
      in_word_r.pack_current_ca       <= in_ch.pack_current_ca;
    end
  end

  // mode state advances only when its result word is taken into the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode            <= MODE_OFF;
      st_r.balancing       <= 1'b0;
      st_r.last_high_ms    <= '0;
      st_r.contactor_close <= 1'b0;
      st_r.charger_enable  <= 1'b0;
      st_r.charger_mv      <= '0;
      st_r.charger_ca      <= '0;
      st_r.balance_on      <= 1'b0;
      st_r.balance_mv      <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_word_r <= res_word;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.error_code          = out_word_r.error_code;
  assign out_ch.contactor_close     = out_word_r.contactor_close;
  assign out_ch.charger_enable      = out_word_r.charger_enable;
  assign out_ch.charger_clear_latch = out_word_r.charger_clear_latch;
  assign out_ch.charger_target_mv   = out_word_r.charger_target_mv;
  assign out_ch.charger_target_ca   = out_word_r.charger_target_ca;
  assign out_ch.balance_on          = out_word_r.balance_on;
  assign out_ch.balance_target_mv   = out_word_r.balance_target_mv;
  assign out_ch.charge_mode         = out_word_r.charge_mode;

  `CCC_ASSERT(a_state_holds_idle, !advance |=> $stable(st_r), "mode state moved without a word")
  `CCC_ASSERT(a_advance_fills_out, advance |=> out_valid_r, "result word lost on advance")
  `CCC_ASSERT(a_fault_stops, (out_valid_r && out_word_r.error_code) |-> (out_word_r.charge_mode == MODE_CODE_OFF && !out_word_r.charger_enable), "fault result not in off")
  `CCC_ASSERT(a_clear_in_init, (out_valid_r && out_word_r.charger_clear_latch) |-> (out_word_r.charge_mode == MODE_CODE_INIT && out_word_r.charger_enable), "latch clear outside init")
  `CCC_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> (!in_valid_r && !out_valid_r), "reset left a word in flight")
endmodule

>>> test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  localparam int SET_TYPICAL    = 0;
  localparam int SET_ZERO       = 1;
  localparam int SET_MAX        = 2;
  localparam int SET_RANDOM     = 3;
  localparam int SET_TIGHT_HYST = 4;

  localparam int CELL_MV_MAX = 8191;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ccc_in_if  in_ch();
  ccc_out_if out_ch();

  cc_cv_charge_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Sequencer state as the controller should hold it
  cfg_t                 seq_cfg = '{13'd3600, 21'd0, 21'd0, 23'd0, 13'd50, 13'd10, 13'd0};
  logic [MODE_W-1:0]    seq_mode = MODE_CODE_OFF;
  logic                 seq_balancing = 1'b0;
  logic [TIME_W-1:0]    seq_last_high_ms = '0;
  logic                 seq_close = 1'b0;
  logic                 seq_chg_en = 1'b0;
  logic [PACK_MV_W-1:0] seq_chg_mv = '0;
  logic [CA_W-1:0]      seq_chg_ca = '0;
  logic                 seq_bal_on = 1'b0;
  logic [MV_W-1:0]      seq_bal_mv = '0;

  out_word_t status_words_due[$];
  int mismatch_count = 0;
  int ticks_sent = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(3_000_000);
    $display("FAIL");
    $finish;
  end

  task automatic advance_charge_sequencer(input in_word_t w, output out_word_t r);
    int cur;
    int diff;
    int pass;
    logic again;
    logic clear_latch;
    logic err;
    logic finished;
    logic [TIME_W-1:0] held_for;
    cur = int'($signed(w.pack_current_ca));
    err = 1'b0;
    clear_latch = 1'b0;
    if (w.cmd == CMD_CHARGE) begin
      if (seq_mode == MODE_CODE_OFF) seq_mode = MODE_CODE_INIT;
    end else if (w.cmd == CMD_DRAIN || w.cmd == CMD_IDLE || w.cmd == CMD_BALANCE) begin
      seq_mode = MODE_CODE_OFF;
      seq_close = 1'b0;
    end
    // init may fall through to CC or CV, which may swap once more
    again = 1'b1;
    for (pass = 0; again && pass < 3; pass++) begin
      again = 1'b0;
      clear_latch = 1'b0;
      case (seq_mode)
        MODE_CODE_OFF: begin
          seq_bal_on = 1'b0;
          seq_chg_en = 1'b0;
          seq_close = 1'b0;
        end
        MODE_CODE_INIT: begin
          seq_bal_on = 1'b0;
          seq_chg_mv = '0;
          seq_chg_ca = '0;
          seq_chg_en = 1'b1;
          seq_last_high_ms = w.now_ms;
          if (!w.contactors_are_closed) begin
            seq_close = 1'b1;
          end else if (w.charger_fault) begin
            clear_latch = 1'b1;
          end else begin
            seq_mode = (w.max_cell_mv < seq_cfg.cell_limit_mv) ? MODE_CODE_CC : MODE_CODE_CV;
            again = 1'b1;
          end
        end
        MODE_CODE_CC, MODE_CODE_CV: begin
          if (w.charger_fault) begin
            seq_chg_en = 1'b0;
            seq_bal_on = 1'b0;
            seq_close = 1'b0;
            seq_mode = MODE_CODE_OFF;
            err = 1'b1;
          end else if (seq_mode == MODE_CODE_CC && w.max_cell_mv >= seq_cfg.cell_limit_mv) begin
            seq_mode = MODE_CODE_CV;
            again = 1'b1;
          end else if (seq_mode == MODE_CODE_CV && w.max_cell_mv < seq_cfg.cell_limit_mv) begin
            seq_mode = MODE_CODE_CC;
            again = 1'b1;
          end else begin
            finished = 1'b0;
            seq_chg_mv = (seq_mode == MODE_CODE_CC) ? seq_cfg.cc_pack_mv : seq_cfg.pack_limit_mv;
            seq_chg_ca = seq_cfg.charge_current_ca;
            seq_chg_en = 1'b1;
            if (seq_mode == MODE_CODE_CV) begin
              if (cur < int'(LOW_CURRENT_CA)) begin
                held_for = w.now_ms - seq_last_high_ms;
                if (held_for >= DONE_HOLD_MS) begin
                  seq_chg_en = 1'b0;
                  seq_bal_on = 1'b0;
                  seq_mode = MODE_CODE_DONE;
                  seq_balancing = 1'b0;
                  finished = 1'b1;
                end
              end else begin
                seq_last_high_ms = w.now_ms;
              end
            end
            if (!finished) begin
              // signed spread: inverted cells give a negative value
              diff = int'(w.max_cell_mv) - int'(w.min_cell_mv);
              if (!seq_balancing && diff > int'(seq_cfg.balance_on_delta_mv))
                seq_balancing = 1'b1;
              else if (seq_balancing && diff < int'(seq_cfg.balance_off_delta_mv))
                seq_balancing = 1'b0;
              seq_bal_on = seq_balancing;
              seq_bal_mv = seq_balancing ? w.min_cell_mv : seq_cfg.balance_idle_mv;
            end
          end
        end
        MODE_CODE_DONE: begin
          seq_close = 1'b0;
        end
        default: begin
        end
      endcase
    end
    r.error_code          = err;
    r.contactor_close     = seq_close;
    r.charger_enable      = seq_chg_en;
    r.charger_clear_latch = clear_latch;
    r.charger_target_mv   = seq_chg_mv;
    r.charger_target_ca   = seq_chg_ca;
    r.balance_on          = seq_bal_on;
    r.balance_target_mv   = seq_bal_mv;
    r.charge_mode         = seq_mode;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Check results first, then predict for the word taken at this edge
  always @(posedge clk) begin
    out_word_t due;
    in_word_t  taken;
    out_word_t r;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (status_words_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with none outstanding, expected none, actual mode %0d",
                   $time, out_ch.charge_mode);
        end else begin
          due = status_words_due.pop_front();
          check_field("error_code", 32'(due.error_code), 32'(out_ch.error_code));
          check_field("contactor_close", 32'(due.contactor_close),
                      32'(out_ch.contactor_close));
          check_field("charger_enable", 32'(due.charger_enable), 32'(out_ch.charger_enable));
          check_field("charger_clear_latch", 32'(due.charger_clear_latch),
                      32'(out_ch.charger_clear_latch));
          check_field("charger_target_mv", 32'(due.charger_target_mv),
                      32'(out_ch.charger_target_mv));
          check_field("charger_target_ca", 32'(due.charger_target_ca),
                      32'(out_ch.charger_target_ca));
          check_field("balance_on", 32'(due.balance_on), 32'(out_ch.balance_on));
          check_field("balance_target_mv", 32'(due.balance_target_mv),
                      32'(out_ch.balance_target_mv));
          check_field("charge_mode", 32'(due.charge_mode), 32'(out_ch.charge_mode));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        taken.cmd                   = in_ch.cmd;
        taken.now_ms                = in_ch.now_ms;
        taken.contactors_are_closed = in_ch.contactors_are_closed;
        taken.charger_fault         = in_ch.charger_fault;
        taken.max_cell_mv           = in_ch.max_cell_mv;
        taken.min_cell_mv           = in_ch.min_cell_mv;
        taken.pack_current_ca       = in_ch.pack_current_ca;
        advance_charge_sequencer(taken, r);
        status_words_due.push_back(r);
      end
    end
  end

  // Result side stalls in stretches, each with its own ready rate
  initial begin
    int left;
    int pct;
    out_ch.ready = 1'b0;
    left = 0;
    pct = 100;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        left = $urandom_range(16, 200);
        case ($urandom_range(0, 3))
          0: pct = 100;
          1: pct = 70;
          2: pct = 40;
          default: pct = 10;
        endcase
      end
      left--;
      out_ch.ready = ($urandom_range(1, 100) <= pct);
    end
  end

  task automatic send_tick(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250) : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid                 = 1'b1;
    in_ch.cmd                   = w.cmd;
    in_ch.now_ms                = w.now_ms;
    in_ch.contactors_are_closed = w.contactors_are_closed;
    in_ch.charger_fault         = w.charger_fault;
    in_ch.max_cell_mv           = w.max_cell_mv;
    in_ch.min_cell_mv           = w.min_cell_mv;
    in_ch.pack_current_ca       = w.pack_current_ca;
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
  endtask

  task automatic send_fields(input logic [CMD_W-1:0] c, input logic [TIME_W-1:0] t,
                             input logic closed, input logic fault,
                             input logic [MV_W-1:0] mx, input logic [MV_W-1:0] mn,
                             input int cur);
    in_word_t w;
    w.cmd                   = c;
    w.now_ms                = t;
    w.contactors_are_closed = closed;
    w.charger_fault         = fault;
    w.max_cell_mv           = mx;
    w.min_cell_mv           = mn;
    w.pack_current_ca       = CUR_W'(cur);
    send_tick(w);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (status_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
  endtask

  task automatic load_settings(input cfg_t c);
    wait_results_drained();
    write_reg(CFG_CELL_LIMIT, CFG_DATA_W'(c.cell_limit_mv));
    write_reg(CFG_PACK_LIMIT, CFG_DATA_W'(c.pack_limit_mv));
    write_reg(CFG_CC_PACK, CFG_DATA_W'(c.cc_pack_mv));
    write_reg(CFG_CHARGE_CUR, c.charge_current_ca);
    write_reg(CFG_BAL_ON, CFG_DATA_W'(c.balance_on_delta_mv));
    write_reg(CFG_BAL_OFF, CFG_DATA_W'(c.balance_off_delta_mv));
    write_reg(CFG_BAL_IDLE, CFG_DATA_W'(c.balance_idle_mv));
    @(negedge clk);
    cfg_we = 1'b0;
    seq_cfg = c;
  endtask

  function automatic cfg_t make_settings(input int kind);
    cfg_t c;
    case (kind)
      SET_ZERO: c = '0;
      SET_MAX:  c = '{13'd5000, 21'd1500000, 21'd1500000, 23'd6400000,
                      13'd5000, 13'd5000, 13'd5000};
      SET_RANDOM: begin
        c.cell_limit_mv        = MV_W'($urandom_range(0, 5000));
        c.pack_limit_mv        = PACK_MV_W'($urandom_range(0, 1500000));
        c.cc_pack_mv           = PACK_MV_W'($urandom_range(0, 1500000));
        c.charge_current_ca    = CA_W'($urandom_range(0, 6400000));
        c.balance_on_delta_mv  = MV_W'($urandom_range(0, 300));
        c.balance_off_delta_mv = MV_W'($urandom_range(0, 300));
        c.balance_idle_mv      = MV_W'($urandom_range(0, 5000));
      end
      SET_TIGHT_HYST: begin
        c.cell_limit_mv        = MV_W'($urandom_range(2500, 4200));
        c.pack_limit_mv        = PACK_MV_W'($urandom_range(0, 1500000));
        c.cc_pack_mv           = PACK_MV_W'($urandom_range(0, 1500000));
        c.charge_current_ca    = CA_W'($urandom_range(0, 6400000));
        c.balance_on_delta_mv  = MV_W'($urandom_range(0, 40));
        // off threshold at or above the on threshold
        c.balance_off_delta_mv = MV_W'(c.balance_on_delta_mv + $urandom_range(0, 60));
        c.balance_idle_mv      = MV_W'($urandom_range(0, 5000));
      end
      default: c = '{13'd3600, 21'd1008000, 21'd1050000, 23'd1000000,
                     13'd50, 13'd10, 13'd3000};
    endcase
    return c;
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w.cmd                   = CMD_W'($urandom);
    w.now_ms                = $urandom;
    w.contactors_are_closed = 1'($urandom_range(0, 1));
    w.charger_fault         = 1'($urandom_range(0, 1));
    w.max_cell_mv           = MV_W'($urandom);
    w.min_cell_mv           = MV_W'($urandom);
    w.pack_current_ca       = CUR_W'($urandom);
    return w;
  endfunction

  function automatic logic [CMD_W-1:0] session_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 82) return CMD_NONE;
    if (r < 88) return CMD_CHARGE;
    if (r < 91) return CMD_DRAIN;
    if (r < 93) return CMD_IDLE;
    if (r < 95) return CMD_BALANCE;
    return CMD_RSVD_5 + CMD_W'($urandom_range(0, 2));
  endfunction

  // Charge request, contactors closing, CC rising into CV, current tapering off
  task automatic run_charge_session(input int n_ticks);
    in_word_t w;
    logic [TIME_W-1:0] t;
    int lim, closed_at, cv_at, taper_at, i, mx, mn, r;
    lim = int'(seq_cfg.cell_limit_mv);
    t = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 120000) : $urandom;
    closed_at = $urandom_range(0, 3);
    cv_at = $urandom_range(1, n_ticks);
    taper_at = $urandom_range(cv_at, n_ticks + 2);
    for (i = 0; i < n_ticks; i++) begin
      w.cmd = (i == 0) ? CMD_CHARGE : session_cmd();
      w.now_ms = t;
      w.contactors_are_closed = (i >= closed_at) && ($urandom_range(0, 19) != 0);
      w.charger_fault = ($urandom_range(0, 24) == 0);
      if ($urandom_range(0, 15) == 0) mx = $urandom_range(0, CELL_MV_MAX);
      else if (i < cv_at) mx = (lim == 0) ? 0 : lim - $urandom_range(1, (lim < 300) ? lim : 300);
      else mx = lim + $urandom_range(0, 300);
      if (mx > CELL_MV_MAX) mx = CELL_MV_MAX;
      if ($urandom_range(0, 9) == 0) mn = mx + $urandom_range(1, 200);
      else mn = mx - $urandom_range(0, 120);
      if (mn > CELL_MV_MAX) mn = CELL_MV_MAX;
      if (mn < 0) mn = 0;
      w.max_cell_mv = MV_W'(mx);
      w.min_cell_mv = MV_W'(mn);
      r = $urandom_range(0, 19);
      if (r == 0) w.pack_current_ca = CUR_W'($urandom);
      else if (r == 1) w.pack_current_ca = LOW_CURRENT_CA - CUR_W'($urandom_range(0, 1));
      else if (i >= taper_at && r < 18)
        w.pack_current_ca = CUR_W'(int'($urandom_range(0, 199)) - 100);
      else w.pack_current_ca = CUR_W'($urandom_range(100, 2000000));
      send_tick(w);
      t = t + (($urandom_range(0, 9) == 0) ? $urandom_range(55000, 65000)
                                           : $urandom_range(0, 25000));
    end
  endtask

  task automatic run_mix(input int n_ticks);
    int start, i, n;
    start = ticks_sent;
    while (ticks_sent - start < n_ticks) begin
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 8);
        for (i = 0; i < n; i++) send_tick(noise_word());
      end else begin
        run_charge_session($urandom_range(4, 30));
      end
      if ($urandom_range(0, 19) == 0) wait_results_drained();
    end
  endtask

  task automatic test_mode_walk();
    load_settings(make_settings(SET_TYPICAL));
    send_fields(CMD_NONE,    32'd0,    1'b0, 1'b0, 13'd0,    13'd0,    0);
    send_fields(CMD_CHARGE,  32'd1000, 1'b0, 1'b0, 13'd3500, 13'd3400, 0);
    // contactors closed but charger faulted: stay in init, pulse the clear
    send_fields(CMD_NONE,    32'd2000, 1'b1, 1'b1, 13'd3500, 13'd3400, 0);
    send_fields(CMD_NONE,    32'd3000, 1'b1, 1'b0, 13'd3500, 13'd3400, 500);
    send_fields(CMD_NONE,    32'd4000, 1'b1, 1'b0, 13'd3650, 13'd3645, 500);
    send_fields(CMD_NONE,    32'd5000, 1'b1, 1'b0, 13'd3599, 13'd3500, 500);
    send_fields(CMD_NONE,    32'd6000, 1'b1, 1'b1, 13'd3599, 13'd3500, 500);
    // straight into CV, then hold low current across the 32-bit wrap
    send_fields(CMD_CHARGE,  32'hFFFF_D8EF, 1'b1, 1'b0, 13'd8191, 13'd0, 8388607);
    send_fields(CMD_NONE,    32'h0000_1000, 1'b1, 1'b0, 13'd3700, 13'd3690, -8388608);
    send_fields(CMD_NONE,    32'h0000_C34E, 1'b1, 1'b0, 13'd3700, 13'd3690, 99);
    send_fields(CMD_NONE,    32'h0000_C34F, 1'b1, 1'b0, 13'd3700, 13'd3690, 0);
    send_fields(CMD_CHARGE,  32'h0001_0000, 1'b1, 1'b0, 13'd3700, 13'd3690, 0);
    send_fields(CMD_RSVD_5,  32'h0001_1000, 1'b1, 1'b0, 13'd3700, 13'd3690, 0);
    send_fields(CMD_DRAIN,   32'h0001_2000, 1'b1, 1'b0, 13'd3700, 13'd3690, 0);
    // inverted cells never start balancing and do stop it
    send_fields(CMD_CHARGE,  32'h0002_0000, 1'b1, 1'b0, 13'd3000, 13'd3100, 500);
    send_fields(CMD_NONE,    32'h0002_1000, 1'b1, 1'b0, 13'd3000, 13'd2900, 500);
    send_fields(CMD_NONE,    32'h0002_2000, 1'b1, 1'b0, 13'd0,    13'd8191, 500);
    send_fields(CMD_NONE,    32'h0002_3000, 1'b1, 1'b0, 13'd3700, 13'd3650, 100);
    send_fields(CMD_IDLE,    32'h0002_4000, 1'b1, 1'b0, 13'd3700, 13'd3650, 100);
    send_fields(CMD_CHARGE,  32'h0002_5000, 1'b0, 1'b0, 13'd3700, 13'd3650, 100);
    send_fields(CMD_BALANCE, 32'h0002_6000, 1'b0, 1'b0, 13'd3700, 13'd3650, 100);
    send_fields(CMD_RSVD_6,  32'h0002_7000, 1'b1, 1'b1, 13'd3700, 13'd3650, 100);
    send_fields(CMD_RSVD_7,  32'h0002_8000, 1'b1, 1'b1, 13'd3700, 13'd3650, 100);
    send_fields(CMD_CHARGE,  32'h0002_9000, 1'b1, 1'b1, 13'd4000, 13'd3900, 100);
    send_fields(CMD_NONE,    32'h0002_A000, 1'b1, 1'b0, 13'd4000, 13'd3900, 100);
    send_fields(CMD_NONE,    32'hFFFF_FFFF, 1'b1, 1'b0, 13'd4000, 13'd3900, 100);
    send_fields(CMD_DRAIN,   32'hFFFF_FFFF, 1'b1, 1'b0, 13'd4000, 13'd3900, 0);
  endtask

  task automatic test_setting_extremes();
    load_settings(make_settings(SET_ZERO));
    run_mix(300);
    load_settings(make_settings(SET_MAX));
    run_mix(300);
  endtask

  task automatic test_random_traffic();
    load_settings(make_settings(SET_RANDOM));
    run_mix(330);
    load_settings(make_settings(SET_TIGHT_HYST));
    run_mix(330);
    load_settings(make_settings(SET_RANDOM));
    run_mix(330);
    load_settings(make_settings(SET_TYPICAL));
    run_mix(330);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.now_ms = '0;
    in_ch.contactors_are_closed = 1'b0;
    in_ch.charger_fault = 1'b0;
    in_ch.max_cell_mv = '0;
    in_ch.min_cell_mv = '0;
    in_ch.pack_current_ca = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_mode_walk();
    test_setting_extremes();
    test_random_traffic();

    wait_results_drained();
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
